[hw/rtl/file_signature_prefix_matcher_top_assert.svh]
// Assertion macros shared by the signature prefix matcher modules.
`ifndef FILE_SIGNATURE_PREFIX_MATCHER_TOP_ASSERT_SVH
`define FILE_SIGNATURE_PREFIX_MATCHER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define FSPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define FSPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FSPM_ASSERT(lbl, clk, rst, prop, msg)
`define FSPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[hw/rtl/fspm_pkg.sv]
// Package with constants, opcodes and beat types of the signature prefix matcher.
package fspm_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int MAX_SIG_LEN = 16;
   localparam int BYTE_W      = 8;
   localparam int ENTRY_W     = $clog2(NUM_ENTRIES);
   localparam int POS_W       = $clog2(MAX_SIG_LEN);
   localparam int LEN_W       = 5;
   localparam int SEEN_W      = $clog2(MAX_SIG_LEN + 1);
   localparam int MASK_W      = 16;
   localparam int COUNT_W     = 5;
   localparam int ROW_W       = NUM_ENTRIES * BYTE_W;

   // Opcodes of an input beat.
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_COMMIT = 2'd2;
   localparam logic [1:0] OP_DATA   = 2'd3;

   typedef logic [ROW_W-1:0] row_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [3:0]        entry_index;
      logic [3:0]        byte_position;
      logic [4:0]        signature_length;
      logic [7:0]        byte_value;
      logic              end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0]  match_mask;
      logic [COUNT_W-1:0] match_count;
   } rsp_type;

   // Controls from the sequencer to the match core.
   typedef struct packed {
      logic              clear;
      logic              commit;
      logic [ENTRY_W-1:0] commit_entry;
      logic [LEN_W-1:0]  commit_len;
      logic              match;
      logic [BYTE_W-1:0] match_byte;
      logic              match_last;
   } ctl_type;

endpackage

[hw/rtl/fspm_pattern_ram.sv]
// Pattern memory: one row per byte position, one byte lane per table entry.
module fspm_pattern_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [fspm_pkg::POS_W-1:0]     wr_row,
   input  logic [fspm_pkg::ENTRY_W-1:0]   wr_lane,
   input  logic [fspm_pkg::BYTE_W-1:0]    wr_byte,
   input  logic                           rd_en,
   input  logic [fspm_pkg::POS_W-1:0]     rd_row,
   output fspm_pkg::row_type              rd_data
);
   import fspm_pkg::*;

   row_type mem [MAX_SIG_LEN];
   row_type rd_data_ff;

   // Byte-lane write of a single pattern byte.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_lane*BYTE_W +: BYTE_W] <= wr_byte;
      end
   end

   // Registered read of a whole row.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/fspm_match_core.sv]
// Match core: entry lengths, valid bits, running match flags and the byte counter.
`include "file_signature_prefix_matcher_top_assert.svh"

module fspm_match_core (
   input  logic                          clock,
   input  logic                          reset,
   input  fspm_pkg::ctl_type             ctl,
   input  fspm_pkg::row_type             rd_row,
   output logic [fspm_pkg::SEEN_W-1:0]   seen,
   output fspm_pkg::rsp_type             result
);
   import fspm_pkg::*;

   logic [LEN_W-1:0]       len_ff [NUM_ENTRIES];
   logic [LEN_W-1:0]       len_in [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [NUM_ENTRIES-1:0] valid_in;
   logic [NUM_ENTRIES-1:0] flag_ff;
   logic [NUM_ENTRIES-1:0] flag_in;
   logic [SEEN_W-1:0]      seen_ff;
   logic [SEEN_W-1:0]      seen_in;
   logic [NUM_ENTRIES-1:0] flag_upd;
   logic [SEEN_W-1:0]      seen_upd;
   logic                   compare_on;
   logic [LEN_W-1:0]       sat_len;
   logic [MASK_W-1:0]      mask_v;
   logic [COUNT_W-1:0]     count_v;

   // Compare the data byte against every entry's byte at the current position.
   always_comb begin
      compare_on = seen_ff < SEEN_W'(MAX_SIG_LEN);
      flag_upd   = flag_ff;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
         if (compare_on && (LEN_W'(seen_ff) < len_ff[e]) &&
             (rd_row[e*BYTE_W +: BYTE_W] != ctl.match_byte)) begin
            flag_upd[e] = 1'b0;
         end
      end
      seen_upd = compare_on ? seen_ff + SEEN_W'(1) : seen_ff;
   end

   // Result of a buffer that ends with this byte.
   always_comb begin
      mask_v  = '0;
      count_v = '0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
         mask_v[e] = valid_ff[e] && flag_upd[e] && (len_ff[e] <= LEN_W'(seen_upd));
         count_v   = count_v + COUNT_W'(mask_v[e]);
      end
   end

   // Next-state of the table and the buffer state.
   always_comb begin
      sat_len  = (ctl.commit_len > LEN_W'(MAX_SIG_LEN)) ? LEN_W'(MAX_SIG_LEN) : ctl.commit_len;
      len_in   = len_ff;
      valid_in = valid_ff;
      flag_in  = flag_ff;
      seen_in  = seen_ff;
      if (ctl.clear) begin
         for (int e = 0; e < NUM_ENTRIES; e++) begin
            len_in[e] = '0;
         end
         valid_in = '0;
         flag_in  = '1;
         seen_in  = '0;
      end else if (ctl.commit) begin
         len_in[ctl.commit_entry]   = sat_len;
         valid_in[ctl.commit_entry] = 1'b1;
      end else if (ctl.match) begin
         if (ctl.match_last) begin
            flag_in = '1;
            seen_in = '0;
         end else begin
            flag_in = flag_upd;
            seen_in = seen_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < NUM_ENTRIES; e++) begin
            len_ff[e] <= '0;
         end
         valid_ff <= '0;
         flag_ff  <= '1;
         seen_ff  <= '0;
      end else begin
         len_ff   <= len_in;
         valid_ff <= valid_in;
         flag_ff  <= flag_in;
         seen_ff  <= seen_in;
      end
   end

   assign seen                = seen_ff;
   assign result.match_mask  = mask_v;
   assign result.match_count = count_v;

   `FSPM_ASSERT(a_seen_bounded, clock, reset, seen_ff <= SEEN_W'(MAX_SIG_LEN), "byte counter beyond maximum length")
   `FSPM_ASSERT_NEXT(a_clear_restarts, clock, reset, ctl.clear, (seen_ff == '0) && (valid_ff == '0) && (&flag_ff), "clear did not restart table and buffer")
   `FSPM_ASSERT_NEXT(a_end_restarts, clock, reset, ctl.match && ctl.match_last && !ctl.clear, (seen_ff == '0) && (&flag_ff), "end of buffer did not restart flags")

endmodule

[hw/rtl/file_signature_prefix_matcher_top.sv]
// Top level of the signature prefix matcher: handshakes, sequencer and result register.
//
// The req channel carries one beat per command: clear the table, write one pattern
// byte, commit an entry's length (which marks it valid), or one data byte of a buffer.
// The rsp channel carries one beat for each data byte flagged as end of buffer: a mask
// of the valid entries whose signature prefixes the buffer, and its population count.
// Table beats leave the sequencer idle. For a data byte the pattern row for the
// current byte position is read from the pattern memory, then every entry is
// compared in parallel on the next cycle, once the registered read holds the row.
// The result of an end-of-buffer byte is loaded into the output register at the edge
// that closes its compare.
// Reset empties the table and restarts the buffer at once; the pattern bytes are not
// cleared and need no sweep, so the block is ready as soon as reset is released.
// The result sits in an output register. While it waits for rsp_ready the block takes
// no new beat, so a stalled receiver holds off the req channel as well.
`include "file_signature_prefix_matcher_top_assert.svh"

module file_signature_prefix_matcher_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fspm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fspm_pkg::rsp_type rsp_payload
);
   import fspm_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MATCH = 1'b1;

   logic     state_ff;
   logic     state_in;
   req_type  item_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_ff;
   logic     req_accept;
   ctl_type  ctl;
   row_type  rd_row;
   rsp_type  core_result;
   logic [SEEN_W-1:0] seen;
   logic     wr_en;
   logic     rd_en;

   // Accept a beat when idle and the output register can take any result.
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   // Sequencer: a data byte waits in the match state for the registered row read.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_payload.opcode == OP_DATA)) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controls for the memory and the match core.
   always_comb begin
      wr_en = req_accept && (req_payload.opcode == OP_WRITE) &&
              (req_payload.entry_index < NUM_ENTRIES) &&
              (req_payload.byte_position < MAX_SIG_LEN);
      rd_en = req_accept && (req_payload.opcode == OP_DATA);
      ctl.clear        = req_accept && (req_payload.opcode == OP_CLEAR);
      ctl.commit       = req_accept && (req_payload.opcode == OP_COMMIT) &&
                         (req_payload.entry_index < NUM_ENTRIES);
      ctl.commit_entry = req_payload.entry_index[ENTRY_W-1:0];
      ctl.commit_len   = req_payload.signature_length;
      ctl.match        = (state_ff == ST_MATCH);
      ctl.match_byte   = item_ff.byte_value;
      ctl.match_last   = item_ff.end_of_buffer;
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_MATCH) && item_ff.end_of_buffer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: the accepted beat and the result.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_payload;
      end
      if ((state_ff == ST_MATCH) && item_ff.end_of_buffer) begin
         rsp_ff <= core_result;
      end
   end

   fspm_pattern_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (req_payload.byte_position[POS_W-1:0]),
      .wr_lane (req_payload.entry_index[ENTRY_W-1:0]),
      .wr_byte (req_payload.byte_value),
      .rd_en   (rd_en),
      .rd_row  (seen[POS_W-1:0]),
      .rd_data (rd_row)
   );

   fspm_match_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .rd_row (rd_row),
      .seen   (seen),
      .result (core_result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `FSPM_ASSERT_NEXT(a_data_enters_match, clock, reset, req_accept && (req_payload.opcode == OP_DATA), state_ff == ST_MATCH, "data beat did not start a compare")
   `FSPM_ASSERT(a_rsp_from_match, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_MATCH), "result appeared without a compare")
   `FSPM_ASSERT(a_count_matches_mask, clock, reset, rsp_valid_ff |-> (rsp_ff.match_count == COUNT_W'($countones(rsp_ff.match_mask))), "match count disagrees with mask")

endmodule
